// ===== rtl/skyline_rect_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Skyline packer assertion macros
// Shared concurrent assertion forms for the skyline packer checkers.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_RECT_PACKER_CORE_DEFINES_SVH
`define SKYLINE_RECT_PACKER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SKP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SKP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/skp_pkg.sv =====
// ----------------------------------------------------------------------------
// Skyline packer package
// Segment record type, sizes and status codes shared by the packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skp_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int CW           = 13;
  localparam int RAM_AW       = IDX_W + 1;

  localparam logic [CW-1:0] RESET_EXTENT = CW'(1024);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] span;
  } seg_t;

endpackage

`default_nettype wire

// ===== rtl/skyline_rect_packer_core.sv =====
// ----------------------------------------------------------------------------
// Skyline rectangle packer
// Bottom-left skyline placement of rectangles in an atlas of configurable size.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid and cannot be held
// off. A clear shows its result in the cycle after it is taken. A placement
// is run by one sequencer over a segment RAM with one read and one write
// port. Each start segment is read (S_TS) and checked against its own
// width and height (S_TL); if it passes, the segments under its span are
// read and tested in turn (S_FR, S_FE), so the search grows with the
// segment count times the segments spanned. A decision state follows. A
// successful placement rebuilds the skyline into the other RAM bank (S_CR,
// S_CE, S_FL), and the result follows in the next cycle. After reset the
// block is busy for one cycle while it writes the first segment.
`default_nettype none

module skyline_rect_packer_core
  import skp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_kind,
  input  wire logic [CW-1:0] in_rect_width,
  input  wire logic [CW-1:0] in_rect_height,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [CW-1:0]      out_origin_x,
  output logic [CW-1:0]      out_origin_y,
  input  wire logic          cfg_we,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [CW-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TS, S_TL, S_FR, S_FE, S_NX, S_DEC, S_CR, S_CE, S_FL, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   aw_r, aw_nxt, ah_r, ah_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            bank_r, bank_nxt;
  logic [CW-1:0]   w_r, w_nxt, h_r, h_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt, wr_r, wr_nxt;
  logic [CW:0]     cov_r, cov_nxt;
  logic [CW-1:0]   y_r, y_nxt, cx_r, cx_nxt, cw_r, cw_nxt;
  logic [CW-1:0]   btop_r, btop_nxt, bw_r, bw_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic [IDX_W-1:0] bi_r, bi_nxt;
  logic            found_r, found_nxt, ins_r, ins_nxt, trim_r, trim_nxt;
  seg_t            pend_r, pend_nxt;
  logic            pendv_r, pendv_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [CW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  seg_t              ram_wdata, rd;

  logic [CW:0]        sum_a, t_val, new_end;
  logic [CW-1:0]      y_max;
  logic signed [15:0] shrink, nw;
  logic               emit;
  seg_t               emit_seg;

  skp_seg_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_comb begin
    case (state_r)
      S_TS, S_TL: ram_raddr = {bank_r, i_r[IDX_W-1:0]};
      S_FR, S_FE: ram_raddr = {bank_r, k_r[IDX_W-1:0]};
      default:    ram_raddr = {bank_r, j_r[IDX_W-1:0]};
    endcase
  end

  assign y_max   = (rd.top > y_r) ? rd.top : y_r;
  assign t_val   = {1'b0, y_r} + {1'b0, h_r};
  assign new_end = {1'b0, bx_r} + {1'b0, w_r};
  assign shrink  = $signed({2'b00, new_end}) - $signed({3'b000, rd.left});
  assign nw      = $signed({3'b000, rd.span}) - shrink;

  always_comb begin
    state_nxt  = state_r;
    aw_nxt     = aw_r;
    ah_nxt     = ah_r;
    count_nxt  = count_r;
    bank_nxt   = bank_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    wr_nxt     = wr_r;
    cov_nxt    = cov_r;
    y_nxt      = y_r;
    cx_nxt     = cx_r;
    cw_nxt     = cw_r;
    btop_nxt   = btop_r;
    bw_nxt     = bw_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    bi_nxt     = bi_r;
    found_nxt  = found_r;
    ins_nxt    = ins_r;
    trim_nxt   = trim_r;
    pend_nxt   = pend_r;
    pendv_nxt  = pendv_r;
    status_nxt = status_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    ram_we     = 1'b0;
    ram_waddr  = {bank_r, IDX_W'(0)};
    ram_wdata  = '{left: '0, top: '0, span: aw_r};
    emit       = 1'b0;
    emit_seg   = rd;
    sum_a      = {1'b0, rd.left} + {1'b0, w_r};

    if (cfg_we) begin
      if (cfg_index == CFG_ATLAS_WIDTH) begin
        aw_nxt = cfg_wdata;
      end else begin
        ah_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{left: '0, top: '0, span: RESET_EXTENT};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK;
          ox_nxt     = '0;
          oy_nxt     = '0;
          if (!in_kind) begin
            ram_we    = 1'b1;
            count_nxt = CNT_W'(1);
            state_nxt = S_OUT;
          end else begin
            w_nxt     = in_rect_width;
            h_nxt     = in_rect_height;
            i_nxt     = '0;
            found_nxt = 1'b0;
            btop_nxt  = ah_r;
            bw_nxt    = aw_r;
            state_nxt = S_TS;
          end
        end
      end
      S_TS: state_nxt = S_TL;
      S_TL: begin
        // Start segment: the rectangle must fit the atlas width from the segment's
        // left edge, and the segment's own top must leave room for the height.
        if (sum_a > {1'b0, aw_r} ||
            ({1'b0, rd.top} + {1'b0, h_r}) > {1'b0, ah_r}) begin
          state_nxt = S_NX;
        end else begin
          y_nxt     = rd.top;
          cx_nxt    = rd.left;
          cw_nxt    = rd.span;
          k_nxt     = i_r;
          cov_nxt   = '0;
          state_nxt = S_FR;
        end
      end
      S_FR: begin
        if (cov_r >= {1'b0, w_r}) begin
          if (t_val < {1'b0, btop_r} || (t_val == {1'b0, btop_r} && cw_r < bw_r)) begin
            found_nxt = 1'b1;
            bi_nxt    = i_r[IDX_W-1:0];
            bw_nxt    = cw_r;
            btop_nxt  = t_val[CW-1:0];
            bx_nxt    = cx_r;
            by_nxt    = y_r;
          end
          state_nxt = S_NX;
        end else if (k_r >= count_r) begin
          state_nxt = S_NX;
        end else begin
          state_nxt = S_FE;
        end
      end
      S_FE: begin
        if (({1'b0, y_max} + {1'b0, h_r}) > {1'b0, ah_r}) begin
          state_nxt = S_NX;
        end else begin
          y_nxt     = y_max;
          cov_nxt   = cov_r + {1'b0, rd.span};
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_FR;
        end
      end
      S_NX: begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == count_r) ? S_DEC : S_TS;
      end
      S_DEC: begin
        if (!found_r) begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_OUT;
        end else if (count_r == CNT_W'(MAX_SEGMENTS)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_OUT;
        end else begin
          j_nxt     = '0;
          wr_nxt    = '0;
          ins_nxt   = 1'b0;
          trim_nxt  = 1'b0;
          pendv_nxt = 1'b0;
          state_nxt = S_CR;
        end
      end
      S_CR: state_nxt = S_CE;
      S_CE: begin
        if (j_r[IDX_W-1:0] == bi_r && !ins_r) begin
          // The placed rectangle enters ahead of its start segment.
          emit     = 1'b1;
          emit_seg = '{left: bx_r, top: btop_r, span: w_r};
          ins_nxt  = 1'b1;
          trim_nxt = 1'b1;
        end else begin
          if (!trim_r) begin
            emit = 1'b1;
          end else if (shrink <= 16'sd0) begin
            emit     = 1'b1;
            trim_nxt = 1'b0;
          end else if (nw > 16'sd0) begin
            emit     = 1'b1;
            emit_seg = '{left: rd.left + shrink[CW-1:0], top: rd.top, span: nw[CW-1:0]};
            trim_nxt = 1'b0;
          end
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = (j_r + CNT_W'(1) == count_r) ? S_FL : S_CR;
        end
      end
      S_FL: begin
        ram_we     = 1'b1;
        ram_waddr  = {~bank_r, wr_r[IDX_W-1:0]};
        ram_wdata  = pend_r;
        count_nxt  = wr_r + CNT_W'(1);
        bank_nxt   = ~bank_r;
        status_nxt = ST_OK;
        ox_nxt     = bx_r;
        oy_nxt     = by_r;
        state_nxt  = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    // Merge on the way out: equal tops fold into the pending segment.
    if (emit) begin
      if (pendv_r && pend_r.top == emit_seg.top) begin
        pend_nxt.span = pend_r.span + emit_seg.span;
      end else begin
        if (pendv_r) begin
          ram_we    = 1'b1;
          ram_waddr = {~bank_r, wr_r[IDX_W-1:0]};
          ram_wdata = pend_r;
          wr_nxt    = wr_r + CNT_W'(1);
        end
        pend_nxt  = emit_seg;
        pendv_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      aw_r    <= RESET_EXTENT;
      ah_r    <= RESET_EXTENT;
      count_r <= CNT_W'(1);
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      aw_r    <= aw_nxt;
      ah_r    <= ah_nxt;
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    wr_r     <= wr_nxt;
    cov_r    <= cov_nxt;
    y_r      <= y_nxt;
    cx_r     <= cx_nxt;
    cw_r     <= cw_nxt;
    btop_r   <= btop_nxt;
    bw_r     <= bw_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    bi_r     <= bi_nxt;
    found_r  <= found_nxt;
    ins_r    <= ins_nxt;
    trim_r   <= trim_nxt;
    pend_r   <= pend_nxt;
    pendv_r  <= pendv_nxt;
    status_r <= status_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_status   = status_r;
  assign out_origin_x = ox_r;
  assign out_origin_y = oy_r;

endmodule

`default_nettype wire

// ===== rtl/skp_seg_ram.sv =====
// ----------------------------------------------------------------------------
// Skyline segment RAM
// One write port and one registered read port; holds both skyline banks.
// ----------------------------------------------------------------------------
`default_nettype none

module skp_seg_ram
  import skp_pkg::*;
#(
  parameter int ADDR_W = RAM_AW
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire seg_t              wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output seg_t                   rdata
);

  seg_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/skp_checker.sv =====
// ----------------------------------------------------------------------------
// Skyline packer port checker
// Watches the packer ports for item and result ordering and result coding.
// ----------------------------------------------------------------------------
`default_nettype none
`include "skyline_rect_packer_core_defines.svh"

module skp_checker
  import skp_pkg::*;
(
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire logic [1:0]    out_status,
  input wire logic [CW-1:0] out_origin_x,
  input wire logic [CW-1:0] out_origin_y
);

  `SKP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `SKP_ASSERT_IMP(a_result_busy, out_valid, busy, "result shown while idle")
  `SKP_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "item gave more than one result")
  `SKP_ASSERT_IMP(a_fail_origin, out_valid && out_status != ST_OK,
                  out_origin_x == '0 && out_origin_y == '0, "failed item reports an origin")
  `SKP_ASSERT_IMP(a_status_code, out_valid,
                  out_status == ST_OK || out_status == ST_NOFIT || out_status == ST_FULL,
                  "unknown status code")

endmodule

bind skyline_rect_packer_core skp_checker u_skp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_origin_x (out_origin_x),
  .out_origin_y (out_origin_y)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Skyline packer testbench
// Drives clear and place items through the command port under several atlas
// sizes; every result is held to a behavioral skyline model or a pinned value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import skp_pkg::*;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_kind;
  logic [CW-1:0] in_rect_width;
  logic [CW-1:0] in_rect_height;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [CW-1:0] out_origin_x;
  logic [CW-1:0] out_origin_y;
  logic          cfg_we;
  logic [0:0]    cfg_index;
  logic [CW-1:0] cfg_wdata;

  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_PLACE = 1'b1;
  localparam int   STALL_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]    status;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } placement_t;

  typedef struct {
    logic          kind;
    int            w;
    int            h;
    bit            pinned;
    logic [1:0]    status;
    int            x;
    int            y;
  } row_t;

  skyline_rect_packer_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_rect_width(in_rect_width), .in_rect_height(in_rect_height),
    .out_valid(out_valid), .out_status(out_status),
    .out_origin_x(out_origin_x), .out_origin_y(out_origin_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor state: atlas limits and the skyline.
  int         atlas_w, atlas_h;
  logic [CW-1:0] sky_left [MAX_SEGMENTS];
  logic [CW-1:0] sky_top  [MAX_SEGMENTS];
  logic [CW-1:0] sky_span [MAX_SEGMENTS];
  int         sky_count;

  placement_t pending_results[$];
  int         items_taken, results_seen, errors, idle_cycles;
  int         n_placed, n_nofit, n_full, n_clear;
  bit         pin_on;
  placement_t pin_val;

  function automatic void sky_clear();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      sky_left[i] = '0; sky_top[i] = '0; sky_span[i] = '0;
    end
    sky_span[0] = CW'(atlas_w);
    sky_count = 1;
  endfunction

  function automatic void sky_drop(int idx);
    for (int i = idx; i < sky_count - 1; i++) begin
      sky_left[i] = sky_left[i+1]; sky_top[i] = sky_top[i+1]; sky_span[i] = sky_span[i+1];
    end
    sky_count--;
  endfunction

  // Resting height of a w x h rectangle whose left edge is segment s; -1 when it
  // leaves the atlas or runs off the end of the skyline.
  function automatic int rest_height(int s, int w, int h);
    int i, covered, y;
    i = s; covered = 0; y = int'(sky_top[s]);
    if (int'(sky_left[s]) + w > atlas_w) return -1;
    if (y + h > atlas_h) return -1;
    while (covered < w) begin
      if (i >= sky_count) return -1;
      if (int'(sky_top[i]) > y) y = int'(sky_top[i]);
      if (y + h > atlas_h) return -1;
      covered += int'(sky_span[i]);
      i++;
    end
    return y;
  endfunction

  function automatic void sky_insert(int idx, int x, int y, int w, int h);
    int i, shrink, nw;
    for (i = sky_count; i > idx; i--) begin
      sky_left[i] = sky_left[i-1]; sky_top[i] = sky_top[i-1]; sky_span[i] = sky_span[i-1];
    end
    sky_left[idx] = CW'(x); sky_top[idx] = CW'(y + h); sky_span[idx] = CW'(w);
    sky_count++;
    i = idx + 1;
    while (i < sky_count) begin
      shrink = int'(sky_left[i-1]) + int'(sky_span[i-1]) - int'(sky_left[i]);
      if (shrink <= 0) break;
      nw = int'(sky_span[i]) - shrink;
      if (nw > 0) begin
        sky_left[i] = CW'(int'(sky_left[i]) + shrink);
        sky_span[i] = CW'(nw);
        break;
      end
      sky_drop(i);
    end
    i = 0;
    while (i + 1 < sky_count) begin
      if (sky_top[i] == sky_top[i+1]) begin
        sky_span[i] = sky_span[i] + sky_span[i+1];
        sky_drop(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic placement_t pack_item(logic kind, int w, int h);
    placement_t r;
    int best_top, best_w, best_x, best_y, best_i, y, t;
    bit found;
    r = '0;
    if (kind == KIND_CLEAR) begin
      sky_clear();
      n_clear++;
      return r;
    end
    best_top = atlas_h; best_w = atlas_w;
    best_x = 0; best_y = 0; best_i = 0; found = 0;
    for (int i = 0; i < sky_count; i++) begin
      y = rest_height(i, w, h);
      if (y >= 0) begin
        t = y + h;
        if (t < best_top || (t == best_top && int'(sky_span[i]) < best_w)) begin
          found = 1; best_i = i; best_w = int'(sky_span[i]); best_top = t;
          best_x = int'(sky_left[i]); best_y = y;
        end
      end
    end
    if (!found) begin
      r.status = ST_NOFIT; n_nofit++;
    end else if (sky_count >= MAX_SEGMENTS) begin
      r.status = ST_FULL; n_full++;
    end else begin
      sky_insert(best_i, best_x, best_y, w, h);
      r.status = ST_OK; r.x = CW'(best_x); r.y = CW'(best_y); n_placed++;
    end
    return r;
  endfunction

  // Accepts items, predicts their results, and checks the results that come out.
  always @(posedge clk) begin
    placement_t p, e;
    if (rst_n) begin
      if (start && !busy) begin
        p = pack_item(in_kind, int'(in_rect_width), int'(in_rect_height));
        pending_results = {pending_results, (pin_on ? pin_val : p)};
        items_taken++;
        idle_cycles = 0;
      end else if (out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (out_valid) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d x=%0d y=%0d", $time,
                   out_status, out_origin_x, out_origin_y);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_origin_x !== e.x) begin
            $display("%0t: origin_x expected %0d got %0d", $time, e.x, out_origin_x);
            errors++;
          end
          if (out_origin_y !== e.y) begin
            $display("%0t: origin_y expected %0d got %0d", $time, e.y, out_origin_y);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  int burst_left;

  // Called at a falling edge; returns at a falling edge after the item is taken and any gap.
  task automatic send(logic kind, int w, int h);
    int taken0, gap;
    taken0 = items_taken;
    in_kind <= kind;
    in_rect_width <= CW'(w);
    in_rect_height <= CW'(h);
    start <= 1'b1;
    do @(negedge clk); while (items_taken == taken0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_atlas(int w, int h);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_ATLAS_WIDTH; cfg_wdata <= CW'(w);
    @(negedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT; cfg_wdata <= CW'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    atlas_w = w; atlas_h = h;
    @(negedge clk);
  endtask

  int pick;

  function automatic int rand_size(int limit);
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(0, 4096);
    if (pick == 2) return 4096;
    if (limit < 4) return $urandom_range(0, limit + 1);
    return $urandom_range(1, limit / 4 + 1);
  endfunction

  row_t directed[] = '{
    '{KIND_PLACE, 0,    0,    1, ST_OK,    0, 0},
    '{KIND_PLACE, 1024, 1024, 1, ST_NOFIT, 0, 0},
    '{KIND_PLACE, 1025, 1,    1, ST_NOFIT, 0, 0},
    '{KIND_PLACE, 8191, 8191, 1, ST_NOFIT, 0, 0},
    '{KIND_PLACE, 4096, 0,    1, ST_NOFIT, 0, 0},
    '{KIND_PLACE, 512,  1024, 1, ST_NOFIT, 0, 0},
    '{KIND_PLACE, 1024, 1023, 1, ST_OK,    0, 0},
    '{KIND_PLACE, 1,    1,    1, ST_NOFIT, 0, 0},
    '{KIND_CLEAR, 8191, 8191, 1, ST_OK,    0, 0},
    '{KIND_PLACE, 100,  10,   1, ST_OK,    0, 0},
    '{KIND_PLACE, 100,  10,   0, ST_OK,    0, 0},
    '{KIND_PLACE, 0,    5,    0, ST_OK,    0, 0},
    '{KIND_PLACE, 50,   0,    0, ST_OK,    0, 0},
    '{KIND_PLACE, 824,  10,   0, ST_OK,    0, 0},
    '{KIND_PLACE, 300,  20,   0, ST_OK,    0, 0},
    '{KIND_PLACE, 1,    1014, 0, ST_OK,    0, 0},
    '{KIND_PLACE, 1024, 1,    0, ST_OK,    0, 0},
    '{KIND_PLACE, 2730, 4095, 0, ST_OK,    0, 0},
    '{KIND_CLEAR, 0,    0,    1, ST_OK,    0, 0}
  };

  int sizes[6][2] = '{'{4096, 4096}, '{1, 1}, '{64, 48}, '{300, 4096}, '{4096, 20},
                      '{1024, 1024}};

  initial begin
    int aw, ah, n;
    rst_n = 1'b0; start = 1'b0; in_kind = KIND_CLEAR;
    in_rect_width = '0; in_rect_height = '0;
    cfg_we = 1'b0; cfg_index = CFG_ATLAS_WIDTH; cfg_wdata = '0;
    items_taken = 0; results_seen = 0; errors = 0; idle_cycles = 0;
    n_placed = 0; n_nofit = 0; n_full = 0; n_clear = 0;
    pin_on = 0; pin_val = '0; burst_left = 0;
    atlas_w = int'(RESET_EXTENT); atlas_h = int'(RESET_EXTENT);
    sky_clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      pin_on = directed[i].pinned;
      pin_val = '{directed[i].status, CW'(directed[i].x), CW'(directed[i].y)};
      send(directed[i].kind, directed[i].w, directed[i].h);
    end
    pin_on = 0;

    // Fill the segment store: a staircase of falling one-pixel columns.
    set_atlas(4096, 4096);
    send(KIND_CLEAR, 0, 0);
    for (int k = 0; k < MAX_SEGMENTS + 2; k++) send(KIND_PLACE, 1, 4000 - k);
    send(KIND_PLACE, 5, 5);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 6) begin
        aw = sizes[ph][0]; ah = sizes[ph][1];
      end else begin
        aw = $urandom_range(1, 4096); ah = $urandom_range(1, 4096);
      end
      set_atlas(aw, ah);
      // Every other phase keeps the old skyline under the new limits.
      if (ph % 2 == 0) send(KIND_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
      n = 55;
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && ph == 3) drain();
        if ($urandom_range(0, 29) == 0)
          send(KIND_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
        else
          send(KIND_PLACE, rand_size(aw), rand_size(ah));
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d items: %0d placed, %0d no fit, %0d store full, %0d clears.",
             items_taken, n_placed, n_nofit, n_full, n_clear);
    $display("Atlas sizes ran from 1x1 to 4096x4096, with and without a clear.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
